### design/fixed_block_pool_allocator_top_defines.svh
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define FBPA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbpa: assertion failed");

// Next-cycle implication, checked while reset is released.
`define FBPA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbpa: assertion failed");

`endif

### design/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

  localparam int unsigned MAX_BLOCKS   = 256;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned NODE_BYTES   = 8;

  localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned POOL_W    = 21;
  localparam int unsigned PAYLOAD_W = 17;
  localparam int unsigned SLOT_W    = PAYLOAD_W + 1;
  localparam int unsigned OFF_W     = POOL_W;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_REBUILD = 2'd2;

  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_ZERO    = 3'd1;
  localparam logic [2:0] STATUS_LARGE   = 3'd2;
  localparam logic [2:0] STATUS_EMPTY   = 3'd3;
  localparam logic [2:0] STATUS_OUTSIDE = 3'd4;
  localparam logic [2:0] STATUS_NOTUSED = 3'd5;
  localparam logic [2:0] STATUS_UNCONF  = 3'd6;

  localparam logic [1:0] REG_BASE    = 2'd0;
  localparam logic [1:0] REG_POOL    = 2'd1;
  localparam logic [1:0] REG_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [1:0]           operation;
    logic [PAYLOAD_W-1:0] request_size;
    logic [ADDR_W-1:0]    block_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  free_blocks;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

endpackage

`default_nettype wire

### design/fbpa_alu.sv
`default_nettype none

// Shared 32-bit adder/subtractor. On subtract, carry high means a >= b.
module fbpa_alu (
  input  fbpa_pkg::alu_req_t req_i,
  output fbpa_pkg::alu_rsp_t rsp_o
);

  logic [fbpa_pkg::ADDR_W:0] full;
  logic [fbpa_pkg::ADDR_W-1:0] b_eff;

  always_comb begin
    b_eff = req_i.sub ? ~req_i.b : req_i.b;
    full  = {1'b0, req_i.a} + {1'b0, b_eff} + {{fbpa_pkg::ADDR_W{1'b0}}, req_i.sub};
    rsp_o.sum   = full[fbpa_pkg::ADDR_W-1:0];
    rsp_o.carry = full[fbpa_pkg::ADDR_W];
  end

endmodule

`default_nettype wire

### design/fbpa_stack_ram.sv
`default_nettype none

// Free stack storage: one write port, one registered read port.
module fbpa_stack_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [fbpa_pkg::IDX_W-1:0] waddr_i,
  input  logic [fbpa_pkg::IDX_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [fbpa_pkg::IDX_W-1:0] raddr_i,
  output logic [fbpa_pkg::IDX_W-1:0] rdata_o
);

  logic [fbpa_pkg::IDX_W-1:0] mem_q [fbpa_pkg::MAX_BLOCKS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator with a LIFO free stack of slot numbers.
// Input channel: valid/ready, one operation per transfer (acquire, release,
// rebuild). Output channel: valid/ready, exactly one result per operation,
// in order. Configuration: APB-style registers at 0x0 (base address), 0x4
// (pool bytes), 0x8 (payload bytes); they take effect at the next rebuild.
// One operation is in flight at a time; in_ready_o is high only when idle.
// What each operation does before its result is emitted:
//   early rejects and null release: nothing further;
//   acquire: stack read, 8 shift-add steps of the slot multiply;
//   release: offset subtract, 21 restoring-division steps, check;
//   rebuild: one stack entry written per cycle for each slot built.
// The input is ready again at the edge where the result turns valid.
// The multiply, offset subtract, division and rebuild walk share one 32-bit
// adder/subtractor. The result waits in an output register; if the receiver
// stalls, a finished next operation waits until that register is taken.
// Reset empties the pool and sets payload bytes to 8; acquires and non-null
// releases before the first good rebuild answer status unconfigured. A good
// rebuild clears the in-use marks of its slots as it walks them.
`default_nettype none

module fixed_block_pool_allocator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fbpa_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fbpa_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::DATA_W-1:0]  pwdata,
  output logic [fbpa_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned IDX_W  = fbpa_pkg::IDX_W;
  localparam int unsigned CNT_W  = fbpa_pkg::CNT_W;
  localparam int unsigned ADDR_W = fbpa_pkg::ADDR_W;
  localparam int unsigned POOL_W = fbpa_pkg::POOL_W;
  localparam int unsigned PAY_W  = fbpa_pkg::PAYLOAD_W;
  localparam int unsigned SLOT_W = fbpa_pkg::SLOT_W;
  localparam int unsigned OFF_W  = fbpa_pkg::OFF_W;
  localparam int unsigned STEP_W = $clog2((OFF_W > IDX_W) ? OFF_W : IDX_W);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ACQ_RD   = 9'b000000010,
    S_ACQ_MUL  = 9'b000000100,
    S_REL_OFF  = 9'b000001000,
    S_REL_DIV  = 9'b000010000,
    S_REL_CHK  = 9'b000100000,
    S_REB_INIT = 9'b001000000,
    S_REB_WALK = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_e;

  // Control state.
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        free_count_q, free_count_d;
  logic [CNT_W-1:0]        block_total_q, block_total_d;
  logic                    built_q, built_d;
  logic                    out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]       base_q;
  logic [POOL_W-1:0]       pool_q;
  logic [PAY_W-1:0]        payload_q;

  // In-use marks, one per slot, with a registered read port.
  logic                    in_use_q [fbpa_pkg::MAX_BLOCKS];
  logic                    use_rdata_q;
  logic                    use_we;
  logic [IDX_W-1:0]        use_waddr;
  logic                    use_wdata;
  logic [IDX_W-1:0]        use_raddr;

  // Datapath state.
  logic [ADDR_W-1:0]       lat_base_hdr_q, lat_base_hdr_d;
  logic [POOL_W-1:0]       lat_pool_q, lat_pool_d;
  logic [PAY_W-1:0]        lat_payload_q, lat_payload_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [ADDR_W-1:0]       acc_q, acc_d;
  logic [ADDR_W-1:0]       addend_q, addend_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [OFF_W-1:0]        div_q, div_d;
  logic [SLOT_W-1:0]       rem_q, rem_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [CNT_W-1:0]        k_q, k_d;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [2:0]              res_status_q, res_status_d;
  logic [ADDR_W-1:0]       res_granted_q, res_granted_d;
  fbpa_pkg::out_item_t     out_data_q, out_data_d;

  fbpa_pkg::alu_req_t      alu_req;
  fbpa_pkg::alu_rsp_t      alu_rsp;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [IDX_W-1:0]        ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [IDX_W-1:0]        ram_rdata;

  logic [1:0]              reg_idx;
  logic                    cfg_wr;
  logic                    in_xfer;
  logic [CNT_W-1:0]        fc_minus_one;
  logic [SLOT_W:0]         div_shift;
  logic                    walk_go;
  logic                    acq_pop;

  fbpa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  fbpa_stack_ram u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration port.
  assign reg_idx = paddr[fbpa_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      fbpa_pkg::REG_BASE:    prdata = base_q;
      fbpa_pkg::REG_POOL:    prdata = fbpa_pkg::DATA_W'(pool_q);
      fbpa_pkg::REG_PAYLOAD: prdata = fbpa_pkg::DATA_W'(payload_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      pool_q    <= '0;
      payload_q <= PAY_W'(8);
    end else if (cfg_wr) begin
      case (reg_idx)
        fbpa_pkg::REG_BASE:    base_q    <= pwdata;
        fbpa_pkg::REG_POOL:    pool_q    <= pwdata[POOL_W-1:0];
        fbpa_pkg::REG_PAYLOAD: payload_q <= pwdata[PAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (use_we) begin
      in_use_q[use_waddr] <= use_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    use_rdata_q <= in_use_q[use_raddr];
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_xfer      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign fc_minus_one = free_count_q - CNT_W'(1);
  assign div_shift    = {rem_q, div_q[OFF_W-1]};

  // The acquire pop is decided at the input transfer so the stack read
  // overlaps the transfer edge.
  assign acq_pop = in_xfer && (in_data_i.operation == fbpa_pkg::OP_ACQUIRE) && built_q
                   && (in_data_i.request_size != '0)
                   && (in_data_i.request_size <= lat_payload_q)
                   && (free_count_q != '0);

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    case (state_q)
      S_ACQ_MUL: begin
        alu_req.a = acc_q;
        alu_req.b = idx_q[0] ? addend_q : '0;
      end
      S_REL_OFF: begin
        alu_req.a   = addr_q;
        alu_req.b   = lat_base_hdr_q;
        alu_req.sub = 1'b1;
      end
      S_REL_DIV: begin
        alu_req.a   = ADDR_W'(div_shift);
        alu_req.b   = ADDR_W'(slot_q);
        alu_req.sub = 1'b1;
      end
      S_REB_INIT: begin
        alu_req.a = base_q;
        alu_req.b = ADDR_W'(fbpa_pkg::HEADER_BYTES);
      end
      S_REB_WALK: begin
        alu_req.a = acc_q;
        alu_req.b = ADDR_W'(slot_q);
      end
      default: begin
      end
    endcase
  end

  assign walk_go = (k_q != CNT_W'(fbpa_pkg::MAX_BLOCKS))
                   && (alu_rsp.sum <= ADDR_W'(lat_pool_q));

  // Sequencer.
  always_comb begin
    state_d        = state_q;
    free_count_d   = free_count_q;
    block_total_d  = block_total_q;
    built_d        = built_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    lat_base_hdr_d = lat_base_hdr_q;
    lat_pool_d     = lat_pool_q;
    lat_payload_d  = lat_payload_q;
    slot_d         = slot_q;
    acc_d          = acc_q;
    addend_d       = addend_q;
    idx_d          = idx_q;
    div_d          = div_q;
    rem_d          = rem_q;
    step_d         = step_q;
    k_d            = k_q;
    addr_d         = addr_q;
    res_status_d   = res_status_q;
    res_granted_d  = res_granted_q;
    out_data_d     = out_data_q;
    ram_we         = 1'b0;
    ram_waddr      = k_q[IDX_W-1:0];
    ram_wdata      = k_q[IDX_W-1:0];
    ram_re         = acq_pop;
    ram_raddr      = fc_minus_one[IDX_W-1:0];
    use_we         = 1'b0;
    use_waddr      = k_q[IDX_W-1:0];
    use_wdata      = 1'b0;
    // Tracks the low quotient bits so the mark is ready when the division ends.
    use_raddr      = {div_q[IDX_W-2:0], alu_rsp.carry};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          addr_d        = in_data_i.block_address;
          res_granted_d = '0;
          res_status_d  = fbpa_pkg::STATUS_OK;
          state_d       = S_EMIT;
          case (in_data_i.operation)
            fbpa_pkg::OP_ACQUIRE: begin
              if (!built_q) begin
                res_status_d = fbpa_pkg::STATUS_UNCONF;
              end else if (in_data_i.request_size == '0) begin
                res_status_d = fbpa_pkg::STATUS_ZERO;
              end else if (in_data_i.request_size > lat_payload_q) begin
                res_status_d = fbpa_pkg::STATUS_LARGE;
              end else if (free_count_q == '0) begin
                res_status_d = fbpa_pkg::STATUS_EMPTY;
              end else begin
                free_count_d = fc_minus_one;
                state_d      = S_ACQ_RD;
              end
            end
            fbpa_pkg::OP_RELEASE: begin
              if (in_data_i.block_address == '0) begin
                res_status_d = fbpa_pkg::STATUS_OK;
              end else if (!built_q) begin
                res_status_d = fbpa_pkg::STATUS_UNCONF;
              end else begin
                state_d = S_REL_OFF;
              end
            end
            fbpa_pkg::OP_REBUILD: begin
              if ((pool_q == '0) || (payload_q < PAY_W'(fbpa_pkg::NODE_BYTES))) begin
                res_status_d = fbpa_pkg::STATUS_UNCONF;
              end else begin
                state_d = S_REB_INIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ACQ_RD: begin
        idx_d     = ram_rdata;
        use_we    = 1'b1;
        use_waddr = ram_rdata;
        use_wdata = 1'b1;
        acc_d     = lat_base_hdr_q;
        addend_d  = ADDR_W'(slot_q);
        step_d    = '0;
        state_d   = S_ACQ_MUL;
      end

      // Shift-add multiply, least significant slot-number bit first.
      S_ACQ_MUL: begin
        acc_d    = alu_rsp.sum;
        addend_d = {addend_q[ADDR_W-2:0], 1'b0};
        idx_d    = idx_q >> 1;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(IDX_W - 1)) begin
          res_status_d  = fbpa_pkg::STATUS_OK;
          res_granted_d = alu_rsp.sum;
          state_d       = S_EMIT;
        end
      end

      S_REL_OFF: begin
        if (alu_rsp.sum >= ADDR_W'(lat_pool_q)) begin
          res_status_d = fbpa_pkg::STATUS_OUTSIDE;
          state_d      = S_EMIT;
        end else begin
          div_d   = alu_rsp.sum[OFF_W-1:0];
          rem_d   = '0;
          step_d  = '0;
          state_d = S_REL_DIV;
        end
      end

      // Restoring division; the dividend register fills with quotient bits.
      S_REL_DIV: begin
        rem_d  = alu_rsp.carry ? alu_rsp.sum[SLOT_W-1:0] : div_shift[SLOT_W-1:0];
        div_d  = {div_q[OFF_W-2:0], alu_rsp.carry};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(OFF_W - 1)) begin
          state_d = S_REL_CHK;
        end
      end

      S_REL_CHK: begin
        state_d = S_EMIT;
        if ((rem_q != '0) || (div_q >= OFF_W'(block_total_q))) begin
          res_status_d = fbpa_pkg::STATUS_OUTSIDE;
        end else if (!use_rdata_q
                     || (free_count_q == CNT_W'(fbpa_pkg::MAX_BLOCKS))) begin
          res_status_d = fbpa_pkg::STATUS_NOTUSED;
        end else begin
          use_we       = 1'b1;
          use_waddr    = div_q[IDX_W-1:0];
          use_wdata    = 1'b0;
          free_count_d = free_count_q + CNT_W'(1);
          ram_we       = 1'b1;
          ram_waddr    = free_count_q[IDX_W-1:0];
          ram_wdata    = div_q[IDX_W-1:0];
          res_status_d = fbpa_pkg::STATUS_OK;
        end
      end

      S_REB_INIT: begin
        lat_base_hdr_d = alu_rsp.sum;
        lat_pool_d     = pool_q;
        lat_payload_d  = payload_q;
        slot_d         = SLOT_W'(payload_q) + SLOT_W'(fbpa_pkg::HEADER_BYTES);
        k_d            = '0;
        acc_d          = '0;
        state_d        = S_REB_WALK;
      end

      // One slot per cycle while the slot cap is not reached and the next slot still ends inside the pool.
      // Each walked slot is pushed and its in-use mark cleared.
      S_REB_WALK: begin
        if (walk_go) begin
          ram_we = 1'b1;
          use_we = 1'b1;
          acc_d  = alu_rsp.sum;
          k_d    = k_q + CNT_W'(1);
        end else begin
          free_count_d  = k_q;
          block_total_d = k_q;
          built_d       = 1'b1;
          res_status_d  = fbpa_pkg::STATUS_OK;
          state_d       = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_d.status          = res_status_q;
          out_data_d.granted_address = res_granted_q;
          out_data_d.free_blocks     = free_count_q;
          out_valid_d                = 1'b1;
          state_d                    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      free_count_q  <= '0;
      block_total_q <= '0;
      built_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      free_count_q  <= free_count_d;
      block_total_q <= block_total_d;
      built_q       <= built_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lat_base_hdr_q <= lat_base_hdr_d;
    lat_pool_q     <= lat_pool_d;
    lat_payload_q  <= lat_payload_d;
    slot_q         <= slot_d;
    acc_q          <= acc_d;
    addend_q       <= addend_d;
    idx_q          <= idx_d;
    div_q          <= div_d;
    rem_q          <= rem_d;
    step_q         <= step_d;
    k_q            <= k_d;
    addr_q         <= addr_d;
    res_status_q   <= res_status_d;
    res_granted_q  <= res_granted_d;
    out_data_q     <= out_data_d;
  end

endmodule

`default_nettype wire

### design/fbpa_checker.sv
`default_nettype none

`include "fixed_block_pool_allocator_top_defines.svh"

module fbpa_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire fbpa_pkg::out_item_t out_data_o
);

  // A result held back by the receiver stays put.
  `FBPA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // Every operation leaves idle at its transfer, so the input closes right after a transfer.
  `FBPA_ASSERT_NXT(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // Only a good acquire hands out an address.
  `FBPA_ASSERT_IMP(a_grant_only_ok, clk_i, rst_ni, out_valid_o && (out_data_o.status != fbpa_pkg::STATUS_OK), out_data_o.granted_address == '0)

  // The free count never exceeds the slot cap.
  `FBPA_ASSERT_IMP(a_free_bound, clk_i, rst_ni, out_valid_o, out_data_o.free_blocks <= 9'(fbpa_pkg::MAX_BLOCKS))

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);

`default_nettype wire
